// ===== rtl/multichannel_frame_ring_buffer_top_defines.svh =====
// Assertion macros shared by the frame ring buffer modules.
`ifndef MULTICHANNEL_FRAME_RING_BUFFER_TOP_DEFINES_SVH
`define MULTICHANNEL_FRAME_RING_BUFFER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define MFRB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define MFRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mfrb_pkg.sv =====
// Shared types and constants of the multichannel frame ring buffer.
package mfrb_pkg;

    localparam int LANES     = 8;
    localparam int WORD_W    = 32;
    localparam int COUNT_W   = 11;
    localparam int CH_W      = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_CAPACITY = 2'd1;

    localparam logic [CH_W-1:0]    CHANNEL_COUNT_RST  = 4'd2;
    localparam logic [COUNT_W-1:0] FRAME_CAPACITY_RST = 11'd1024;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } t_action;

    typedef logic [LANES-1:0][WORD_W-1:0] t_lanes;

    typedef struct packed {
        logic accept;   // input request taken this cycle
        logic capture;  // load pop read data into the result register
    } t_dp_cmd;

    typedef struct packed {
        logic req_pop;  // pending input request is a pop
    } t_dp_stat;

endpackage

// ===== rtl/mfrb_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module mfrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mfrb_ctrl.sv =====
// Request sequencer of the frame ring buffer: accept, memory read wait, result hold.
`include "multichannel_frame_ring_buffer_top_defines.svh"

module mfrb_ctrl
    import mfrb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd.accept  = 1'b0;
        o_cmd.capture = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_stat.req_pop ? S_READ : S_OUT;
                end
            end
            S_READ: begin
                o_cmd.capture = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    `MFRB_ASSERT_NEXT(a_pop_waits_read, o_cmd.accept && i_stat.req_pop, r_state == S_READ, "pop request did not wait for the memory read")
    `MFRB_ASSERT_NEXT(a_result_held, o_out_valid && i_out_stall, o_out_valid, "stalled result was dropped")

endmodule

// ===== rtl/mfrb_dp.sv =====
// Datapath of the frame ring buffer: configuration, ring pointers, sample banks, result register.
`include "multichannel_frame_ring_buffer_top_defines.svh"

module mfrb_dp
    import mfrb_pkg::*;
#(
    parameter int MAX_FRAMES   = 1024,
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_action,
    input  t_lanes                i_sample_in,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output t_lanes                o_sample_out,
    output logic                  o_frame_valid,
    output logic                  o_oldest_dropped,
    output logic [COUNT_W-1:0]    o_frames_stored
);

    localparam int FW = $clog2(MAX_FRAMES);

    logic [CH_W-1:0]    r_channel_count;
    logic [COUNT_W-1:0] r_frame_capacity;
    logic [FW-1:0]      r_read_frame;
    logic [FW-1:0]      r_write_frame;
    logic [COUNT_W-1:0] r_frame_count;
    logic               r_pend_hit;

    logic [FW-1:0]      n_read_frame;
    logic [FW-1:0]      n_write_frame;
    logic [COUNT_W-1:0] n_frame_count;

    t_lanes             r_sample_out;
    logic               r_frame_valid;
    logic               r_oldest_dropped;
    logic [COUNT_W-1:0] r_frames_stored;

    logic [CH_W-1:0]    ch_eff;
    logic [COUNT_W-1:0] cap_eff;
    logic               push_store;
    logic               pop_hit;
    logic               drop;
    t_lanes             rd_lane;
    logic [SAMPLE_BITS-1:0] bank_rdata [MAX_CHANNELS];

    function automatic logic [FW-1:0] ring_next(input logic [FW-1:0] p,
                                                input logic [COUNT_W-1:0] cap);
        logic [FW-1:0] q;
        if (32'(p) + 32'd1 == 32'(cap)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    // A channel count of zero behaves as one; counts above MAX_CHANNELS saturate.
    assign ch_eff = (r_channel_count == '0) ? CH_W'(1) :
                    (32'(r_channel_count) > MAX_CHANNELS) ? CH_W'(MAX_CHANNELS) :
                    r_channel_count;
    assign cap_eff = (32'(r_frame_capacity) > MAX_FRAMES) ? COUNT_W'(MAX_FRAMES) :
                     r_frame_capacity;

    assign o_stat.req_pop = (i_action == ACT_POP);

    always_comb begin
        n_read_frame  = r_read_frame;
        n_write_frame = r_write_frame;
        n_frame_count = r_frame_count;
        push_store    = 1'b0;
        pop_hit       = 1'b0;
        drop          = 1'b0;
        if (i_cmd.accept) begin
            if (i_action == ACT_PUSH) begin
                if (cap_eff != '0) begin
                    push_store = 1'b1;
                    // A full ring gives up its oldest frame to make room.
                    if (r_frame_count >= cap_eff) begin
                        drop         = 1'b1;
                        n_read_frame = ring_next(r_read_frame, cap_eff);
                    end else begin
                        n_frame_count = r_frame_count + 1'b1;
                    end
                    n_write_frame = ring_next(r_write_frame, cap_eff);
                end
            end else if (cap_eff != '0 && r_frame_count != '0) begin
                pop_hit       = 1'b1;
                n_read_frame  = ring_next(r_read_frame, cap_eff);
                n_frame_count = r_frame_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count  <= CHANNEL_COUNT_RST;
            r_frame_capacity <= FRAME_CAPACITY_RST;
            r_read_frame     <= '0;
            r_write_frame    <= '0;
            r_frame_count    <= '0;
            r_pend_hit       <= 1'b0;
        end else if (i_cfg_valid &&
                     (i_cfg_index == CFG_CHANNEL_COUNT ||
                      i_cfg_index == CFG_FRAME_CAPACITY)) begin
            // Either register write empties the ring.
            if (i_cfg_index == CFG_CHANNEL_COUNT) begin
                r_channel_count <= i_cfg_data[CH_W-1:0];
            end else begin
                r_frame_capacity <= i_cfg_data;
            end
            r_read_frame  <= '0;
            r_write_frame <= '0;
            r_frame_count <= '0;
        end else begin
            r_read_frame  <= n_read_frame;
            r_write_frame <= n_write_frame;
            r_frame_count <= n_frame_count;
            if (i_cmd.accept) begin
                r_pend_hit <= pop_hit;
            end
        end
    end

    // One bank per channel, all addressed by frame index.
    for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_bank
        mfrb_ram #(
            .WIDTH (SAMPLE_BITS),
            .DEPTH (MAX_FRAMES)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (push_store && (CH_W'(c) < ch_eff)),
            .i_waddr (r_write_frame),
            .i_wdata (i_sample_in[c][SAMPLE_BITS-1:0]),
            .i_re    (i_cmd.accept),
            .i_raddr (r_read_frame),
            .o_rdata (bank_rdata[c])
        );
    end

    for (genvar c = 0; c < LANES; c++) begin : g_lane
        if (c < MAX_CHANNELS) begin : g_used
            assign rd_lane[c] = (r_pend_hit && CH_W'(c) < ch_eff) ?
                                WORD_W'(bank_rdata[c]) : '0;
        end else begin : g_unused
            assign rd_lane[c] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_action == ACT_PUSH) begin
            r_sample_out     <= '0;
            r_frame_valid    <= 1'b0;
            r_oldest_dropped <= drop;
            r_frames_stored  <= n_frame_count;
        end else if (i_cmd.capture) begin
            r_sample_out     <= rd_lane;
            r_frame_valid    <= r_pend_hit;
            r_oldest_dropped <= 1'b0;
            r_frames_stored  <= r_frame_count;
        end
    end

    assign o_sample_out     = r_sample_out;
    assign o_frame_valid    = r_frame_valid;
    assign o_oldest_dropped = r_oldest_dropped;
    assign o_frames_stored  = r_frames_stored;

    `MFRB_ASSERT_NOW(a_count_in_cap, 1'b1, r_frame_count <= cap_eff, "frame count exceeds capacity")
    `MFRB_ASSERT_NOW(a_ptr_in_cap, cap_eff != '0, (32'(r_read_frame) < 32'(cap_eff)) && (32'(r_write_frame) < 32'(cap_eff)), "ring pointer outside capacity")

endmodule

// ===== rtl/multichannel_frame_ring_buffer_top.sv =====
// Top level of the multichannel frame ring buffer.
// Push: result valid in the cycle after the request is taken; pop: after the extra S_READ state (registered bank read).
// One request is in flight at a time: a new request is taken only once the last result has left,
// because of the memory read stage and the single result register.
// Reset is synchronous, active low: configuration returns to 2 channels, 1024 frames, empty ring.
// Sample memory is not cleared; no clearing pass is run, so requests are taken right after reset.
module multichannel_frame_ring_buffer_top
    import mfrb_pkg::*;
#(
    parameter int MAX_FRAMES   = 1024,
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  logic [WORD_W-1:0]     i_sample_in_0,
    input  logic [WORD_W-1:0]     i_sample_in_1,
    input  logic [WORD_W-1:0]     i_sample_in_2,
    input  logic [WORD_W-1:0]     i_sample_in_3,
    input  logic [WORD_W-1:0]     i_sample_in_4,
    input  logic [WORD_W-1:0]     i_sample_in_5,
    input  logic [WORD_W-1:0]     i_sample_in_6,
    input  logic [WORD_W-1:0]     i_sample_in_7,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [WORD_W-1:0]     o_sample_out_0,
    output logic [WORD_W-1:0]     o_sample_out_1,
    output logic [WORD_W-1:0]     o_sample_out_2,
    output logic [WORD_W-1:0]     o_sample_out_3,
    output logic [WORD_W-1:0]     o_sample_out_4,
    output logic [WORD_W-1:0]     o_sample_out_5,
    output logic [WORD_W-1:0]     o_sample_out_6,
    output logic [WORD_W-1:0]     o_sample_out_7,
    output logic                  o_frame_valid,
    output logic                  o_oldest_dropped,
    output logic [COUNT_W-1:0]    o_frames_stored
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_lanes   sample_in;
    t_lanes   sample_out;

    assign o_cfg_ready = 1'b1;

    assign sample_in[0] = i_sample_in_0;
    assign sample_in[1] = i_sample_in_1;
    assign sample_in[2] = i_sample_in_2;
    assign sample_in[3] = i_sample_in_3;
    assign sample_in[4] = i_sample_in_4;
    assign sample_in[5] = i_sample_in_5;
    assign sample_in[6] = i_sample_in_6;
    assign sample_in[7] = i_sample_in_7;

    assign o_sample_out_0 = sample_out[0];
    assign o_sample_out_1 = sample_out[1];
    assign o_sample_out_2 = sample_out[2];
    assign o_sample_out_3 = sample_out[3];
    assign o_sample_out_4 = sample_out[4];
    assign o_sample_out_5 = sample_out[5];
    assign o_sample_out_6 = sample_out[6];
    assign o_sample_out_7 = sample_out[7];

    mfrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mfrb_dp #(
        .MAX_FRAMES   (MAX_FRAMES),
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_action),
        .i_sample_in      (sample_in),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_sample_out     (sample_out),
        .o_frame_valid    (o_frame_valid),
        .o_oldest_dropped (o_oldest_dropped),
        .o_frames_stored  (o_frames_stored)
    );

endmodule
